/* src/assert_macros.svh */
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// a holds -> b holds in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("assertion failed");

// a holds -> b holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

/* src/gmps_pkg.sv */
package gmps_pkg;

	localparam int MAX_COLS_DEF  = 1024;
	localparam int CELL_BITS_DEF = 16;

	localparam int VALUE_W = 16;
	localparam int WIDTH_W = 11;
	localparam int SUM_W   = 32;

	localparam logic [WIDTH_W-1:0] ROW_WIDTH_RST = 11'd1024;

	typedef logic [SUM_W-1:0] sum_t;

	// output queue status toward the core
	typedef struct packed {
		logic [1:0] count;
		logic       pop;
	} oq_stat_t;

endpackage

/* src/gmps_out_queue.sv */
module gmps_out_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  gmps_pkg::sum_t    push_data,
	output gmps_pkg::oq_stat_t stat,
	output logic              out_valid,
	input  logic              out_ready,
	output gmps_pkg::sum_t    best_sum
);

	gmps_pkg::sum_t data_q [2];
	logic           rd_ptr_q;
	logic           wr_ptr_q;
	logic [1:0]     count_q;
	logic           pop;

	assign out_valid  = (count_q != 2'd0);
	assign pop        = out_valid && out_ready;
	assign best_sum   = data_q[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.pop   = pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			data_q[wr_ptr_q] <= push_data;
	end

endmodule

/* src/grid_max_path_sum.sv */
// Grid maximum path sum over a streamed grid.
// Input channel (in_valid/in_ready): one row-major cell word per cycle while
// in_ready is high, cell_value plus last_cell marking the grid's final cell.
// Output channel (out_valid/out_ready): one best_sum word per grid, the best
// right/down path sum to the last cell, saturated at 32 bits.
// Config: cfg_wr_en/cfg_wr_data set the row width (0 acts as 1, values above
// MAX_COLS act as MAX_COLS); write it only while the block is idle.
// Throughput: one cell per cycle while in_ready is high. Each cell reads its
// column of the row-sum RAM at accept and writes it back the next cycle; a
// same-column access in consecutive cycles (width 1) is forwarded from the
// sum register. A result word is registered in s1, then in the output queue.
// A two-word output queue absorbs receiver stalls; in_ready drops only when
// it could not hold the result of a last cell.
// Reset: row width 1024, a new grid starts; the row-sum RAM is not cleared
// (every entry is written in the first row before it is read).
`include "assert_macros.svh"

module grid_max_path_sum #(
	parameter int MAX_COLS  = gmps_pkg::MAX_COLS_DEF,
	parameter int CELL_BITS = gmps_pkg::CELL_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [gmps_pkg::VALUE_W-1:0]  cell_value,
	input  logic                          last_cell,
	output logic                          out_valid,
	input  logic                          out_ready,
	output gmps_pkg::sum_t                best_sum,
	input  logic                          cfg_wr_en,
	input  logic [gmps_pkg::WIDTH_W-1:0]  cfg_wr_data
);

	localparam int COL_BITS = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int CNT_BITS = $clog2(MAX_COLS + 1);
	localparam logic [gmps_pkg::VALUE_W-1:0] CELL_MASK =
		(CELL_BITS >= gmps_pkg::VALUE_W) ? '1 :
		gmps_pkg::VALUE_W'((32'd1 << CELL_BITS) - 32'd1);

	logic [gmps_pkg::WIDTH_W-1:0] row_width_q;
	logic [COL_BITS-1:0]          col_q;
	logic                         first_row_q;
	gmps_pkg::sum_t               left_sum_q;

	logic                         valid_s1;
	logic                         last_s1;
	logic                         first_s1;
	logic                         fwd_s1;
	logic [COL_BITS-1:0]          col_s1;
	logic [gmps_pkg::VALUE_W-1:0] value_s1;

	gmps_pkg::sum_t               row_ram [MAX_COLS];
	gmps_pkg::sum_t               rd_data_q;

	logic                         accept;
	logic [CNT_BITS-1:0]          w_eff;
	logic [CNT_BITS-1:0]          col_inc;
	logic                         row_end;
	gmps_pkg::sum_t               up_sum;
	gmps_pkg::sum_t               prev_sum;
	logic [gmps_pkg::SUM_W:0]     raw_sum;
	gmps_pkg::sum_t               sum;
	logic [2:0]                   pending;
	gmps_pkg::oq_stat_t           oq_stat;
	logic                         push;

	// results that will occupy the queue after this edge
	assign pending  = 3'(oq_stat.count) + 3'(valid_s1 && last_s1) - 3'(oq_stat.pop);
	assign in_ready = (pending < 3'd2);
	assign accept   = in_valid && in_ready;
	assign push     = valid_s1 && last_s1;

	always_comb begin
		if (row_width_q == '0)
			w_eff = CNT_BITS'(1);
		else if (32'(row_width_q) > MAX_COLS)
			w_eff = CNT_BITS'(MAX_COLS);
		else
			w_eff = CNT_BITS'(row_width_q);
		col_inc = CNT_BITS'(col_q) + CNT_BITS'(1);
		row_end = (col_inc >= w_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= gmps_pkg::ROW_WIDTH_RST;
		end else if (cfg_wr_en) begin
			row_width_q <= cfg_wr_data;
		end
	end

	// column tracking at accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			first_row_q <= 1'b1;
		end else if (accept) begin
			if (last_cell) begin
				col_q       <= '0;
				first_row_q <= 1'b1;
			end else if (row_end) begin
				col_q       <= '0;
				first_row_q <= 1'b0;
			end else begin
				col_q <= COL_BITS'(col_inc);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				last_s1 <= last_cell;
				// the cell in s1 writes this column at the same edge
				fwd_s1  <= valid_s1 && (col_s1 == col_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			first_s1 <= first_row_q;
			col_s1   <= col_q;
			value_s1 <= cell_value & CELL_MASK;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			rd_data_q <= row_ram[col_q];
		if (valid_s1)
			row_ram[col_s1] <= sum;
	end

	always_comb begin
		up_sum = fwd_s1 ? left_sum_q : rd_data_q;
		if (first_s1)
			prev_sum = (col_s1 == '0) ? '0 : left_sum_q;
		else if (col_s1 == '0)
			prev_sum = up_sum;
		else
			prev_sum = (up_sum > left_sum_q) ? up_sum : left_sum_q;
		raw_sum = {1'b0, prev_sum} + (gmps_pkg::SUM_W + 1)'(value_s1);
		sum     = raw_sum[gmps_pkg::SUM_W] ? '1 : raw_sum[gmps_pkg::SUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_sum_q <= '0;
		end else if (valid_s1) begin
			left_sum_q <= sum;
		end
	end

	gmps_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (sum),
		.stat      (oq_stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.best_sum  (best_sum)
	);

	`ASSERT_IMPLIES(a_no_overflow, clk, arst_n, push && (oq_stat.count == 2'd2), oq_stat.pop)
	`ASSERT_NEXT(a_last_to_s1, clk, arst_n, accept && last_cell, valid_s1 && last_s1)
	`ASSERT_IMPLIES(a_col_range, clk, arst_n, 1'b1, 32'(col_q) < MAX_COLS)
	`ASSERT_NEXT(a_fwd_chain, clk, arst_n, accept && valid_s1 && (col_s1 == col_q), fwd_s1)

endmodule

/* sim/grid_max_path_sum_test.sv */
module grid_max_path_sum_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COL_W         = $clog2(gmps_pkg::MAX_COLS_DEF);
	localparam int IDLE_PCT      = 36;
	localparam int SETTLE_CYCLES = 4;
	localparam int STALL_LIMIT   = 4000;
	localparam int RANDOM_CELLS  = 750;
	localparam int WIDE_CELLS    = 40;
	localparam int CALM_CELLS    = 60;
	localparam int CALM_GRIDS    = 20;

	logic                         clk         = 1'b0;
	logic                         arst_n      = 1'b0;
	logic                         in_valid    = 1'b0;
	logic                         in_ready;
	logic [gmps_pkg::VALUE_W-1:0] cell_value  = '0;
	logic                         last_cell   = 1'b0;
	logic                         out_valid;
	logic                         out_ready   = 1'b0;
	gmps_pkg::sum_t               best_sum;
	logic                         cfg_wr_en   = 1'b0;
	logic [gmps_pkg::WIDTH_W-1:0] cfg_wr_data = '0;

	bit calm         = 1'b0;
	int errors       = 0;
	int stall_cycles = 0;

	// predicted block state
	gmps_pkg::sum_t               row_best [gmps_pkg::MAX_COLS_DEF];
	gmps_pkg::sum_t               left_best = '0;
	logic [COL_W-1:0]             next_col  = '0;
	logic                         top_row   = 1'b1;
	logic [gmps_pkg::WIDTH_W-1:0] width_cfg = gmps_pkg::ROW_WIDTH_RST;
	gmps_pkg::sum_t               expected_sums [$];

	grid_max_path_sum dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cell_value  (cell_value),
		.last_cell   (last_cell),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.best_sum    (best_sum),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always #4 clk = ~clk;

	function automatic int cols_per_row();
		if (width_cfg == 0)
			return 1;
		if (width_cfg > gmps_pkg::MAX_COLS_DEF)
			return gmps_pkg::MAX_COLS_DEF;
		return int'(width_cfg);
	endfunction

	function automatic void advance_grid(input logic [gmps_pkg::VALUE_W-1:0] v,
		input logic last);
		gmps_pkg::sum_t               up;
		gmps_pkg::sum_t               prev;
		gmps_pkg::sum_t               sum;
		logic [gmps_pkg::SUM_W:0]     total;
		up = row_best[next_col];
		if (top_row)
			prev = (next_col == 0) ? '0 : left_best;
		else if (next_col == 0)
			prev = up;
		else
			prev = (up > left_best) ? up : left_best;
		total = {1'b0, prev} + {{(gmps_pkg::SUM_W + 1 - gmps_pkg::VALUE_W){1'b0}}, v};
		sum = total[gmps_pkg::SUM_W] ? '1 : total[gmps_pkg::SUM_W-1:0];
		row_best[next_col] = sum;
		left_best = sum;
		if (last) begin
			expected_sums.push_back(sum);
			left_best = '0;
			next_col = '0;
			top_row = 1'b1;
		end else if (int'(next_col) + 1 >= cols_per_row()) begin
			// also covers a column left beyond a width that shrank mid-grid
			left_best = '0;
			next_col = '0;
			top_row = 1'b0;
		end else begin
			next_col = next_col + 1'b1;
		end
	endfunction

	function automatic logic [gmps_pkg::VALUE_W-1:0] rand_cell();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return gmps_pkg::VALUE_W'($urandom);
		endcase
	endfunction

	task automatic send_cell(input logic [gmps_pkg::VALUE_W-1:0] v, input logic last);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cell_value <= v;
		last_cell <= last;
		do @(posedge clk); while (!in_ready);
		advance_grid(v, last);
	endtask

	task automatic send_run(input int n, input bit end_grid);
		for (int i = 0; i < n; i++)
			send_cell(rand_cell(), end_grid && (i == n - 1));
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		while (expected_sums.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_width(input logic [gmps_pkg::WIDTH_W-1:0] w);
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= w;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		width_cfg = w;
	endtask

	// reset width of 1024; this first row writes the low row-sum entries
	task automatic test_reset_width();
		send_cell('1, 1'b0);
		send_run(WIDE_CELLS - 1, 1'b1);
	endtask

	task automatic test_width_extremes();
		set_width('0);
		send_run(5, 1'b1);
		set_width(gmps_pkg::WIDTH_W'(1));
		send_cell('1, 1'b0);
		send_cell('0, 1'b0);
		send_cell('1, 1'b1);
		// all ones clamps to 1024 columns
		set_width('1);
		send_run(WIDE_CELLS, 1'b1);
	endtask

	task automatic test_small_grids();
		set_width(gmps_pkg::WIDTH_W'(3));
		send_cell(16'd1, 1'b0);
		send_cell(16'd3, 1'b0);
		send_cell(16'd1, 1'b0);
		send_cell(16'd1, 1'b0);
		send_cell(16'd5, 1'b0);
		send_cell(16'd1, 1'b0);
		send_cell(16'd4, 1'b0);
		send_cell(16'd2, 1'b0);
		send_cell(16'd1, 1'b1);
		// single-cell grid
		send_cell(16'd7, 1'b1);
		// grid cut short at the first column of row two
		send_cell(16'd2, 1'b0);
		send_cell(16'd9, 1'b0);
		send_cell(16'd4, 1'b0);
		send_cell(16'd6, 1'b1);
		send_run(3, 1'b1);
	endtask

	task automatic test_width_change_mid_grid();
		set_width(gmps_pkg::WIDTH_W'(8));
		send_run(16, 1'b1);
		send_run(6, 1'b0);
		// next column already past the new width: that cell closes the row
		set_width(gmps_pkg::WIDTH_W'(4));
		send_run(5, 1'b1);
		send_run(5, 1'b0);
		// grow again; the upper columns hold sums from the earlier grid
		set_width(gmps_pkg::WIDTH_W'(8));
		send_run(10, 1'b1);
	endtask

	// no idling on either side: one-column chain, then single-cell grids
	task automatic test_no_idle();
		set_width(gmps_pkg::WIDTH_W'(1));
		calm = 1'b1;
		send_run(CALM_CELLS, 1'b1);
		for (int i = 0; i < CALM_GRIDS; i++)
			send_cell(rand_cell(), 1'b1);
		calm = 1'b0;
		send_run(4, 1'b1);
	endtask

	task automatic test_random_grids();
		int sent;
		int cols;
		int n;
		int pick;
		sent = 0;
		while (sent < RANDOM_CELLS) begin
			if ($urandom_range(3) == 0) begin
				pick = $urandom_range(99);
				if (pick < 70)
					set_width(gmps_pkg::WIDTH_W'($urandom_range(1, 8)));
				else if (pick < 92)
					set_width(gmps_pkg::WIDTH_W'($urandom_range(9, 40)));
				else
					set_width('0);
			end
			cols = cols_per_row();
			n = cols * $urandom_range(1, 5);
			// some grids end early, anywhere in a row
			if ($urandom_range(9) == 0)
				n = $urandom_range(1, n);
			send_run(n, 1'b1);
			sent += n;
			if ($urandom_range(7) == 0)
				wait_results();
		end
	endtask

	always @(posedge clk)
		out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin
		gmps_pkg::sum_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_sums.size() == 0) begin
				errors++;
				$display("%0t: unexpected word: expected none, actual best_sum %h",
					$time, best_sum);
			end else begin
				want = expected_sums.pop_front();
				if (best_sum !== want) begin
					errors++;
					$display("%0t: best_sum mismatch: expected %h, actual %h",
						$time, want, best_sum);
				end
			end
		end
	end

	// nothing accepted on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("grid_max_path_sum_test: errors");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < gmps_pkg::MAX_COLS_DEF; i++)
			row_best[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_width();
		test_width_extremes();
		test_small_grids();
		test_width_change_mid_grid();
		test_no_idle();
		test_random_grids();

		wait_results();
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && expected_sums.size() == 0)
			$display("grid_max_path_sum_test: clean");
		else
			$display("grid_max_path_sum_test: errors");
		$finish;
	end

endmodule
